// ----- rtl/core/wpe_pkg.sv -----
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared types and constants for the window pooling engine.
// ----------------------------------------------------------------------------
package wpe_pkg;

  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_KERNEL = 8;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = MAX_HEIGHT * MAX_WIDTH;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 23;   // 64 samples of 16 bits
  localparam int MAG_W      = 24;   // 2*|sum| + d
  localparam int DIV_W      = 7;    // divisor up to 64

  localparam logic [1:0] MODE_MAX  = 2'd0;
  localparam logic [1:0] MODE_CLIP = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_KH   = 3'd1;
  localparam logic [2:0] REG_KW   = 3'd2;
  localparam logic [2:0] REG_SH   = 3'd3;
  localparam logic [2:0] REG_SW   = 3'd4;
  localparam logic [2:0] REG_PAD  = 3'd5;
  localparam logic [2:0] REG_PH   = 3'd6;
  localparam logic [2:0] REG_PW   = 3'd7;

  typedef struct packed {
    logic [1:0] pool_mode;
    logic [3:0] kernel_height;
    logic [3:0] kernel_width;
    logic [3:0] stride_height;
    logic [3:0] stride_width;
    logic [5:0] pad_offsets;
    logic [6:0] plane_height;
    logic [6:0] plane_width;
  } cfg_t;

endpackage

// ----- rtl/core/window_pooling_engine.sv -----
// ----------------------------------------------------------------------------
// window_pooling_engine
// 2-D max / mean pooling over one 64x64 plane of Q8.8 samples.
// ----------------------------------------------------------------------------
// A write leaves busy low. A request holds busy through a setup state, a
// scan that reads each cell of the clipped window in turn (up to 64, from
// the single plane memory port), a drain state for the last read and a
// finishing state; max pooling posts its result at the end of that. Mean
// pooling adds the 24-step bit-serial divide plus its handoff.
// Unsupported or empty windows answer right after the setup cycle. Results
// appear for one cycle on out_valid and cannot be stalled.
module window_pooling_engine
  import wpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic signed [15:0] in_sample,
  output logic        out_valid,
  output logic signed [15:0] out_pooled_value,
  output logic [6:0]  out_cells_used,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_SCAN, S_LAST, S_DIV, S_WAIT} state_t;

  cfg_t cfg;
  wpe_cfg_regs u_cfg (.clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg);

  state_t state_r;
  logic [3:0] kh, kw;
  logic [2:0] pad_t, pad_l;
  logic [6:0] ph, pw;
  assign kh    = (cfg.kernel_height > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : cfg.kernel_height;
  assign kw    = (cfg.kernel_width > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : cfg.kernel_width;
  assign pad_t = cfg.pad_offsets[5:3];
  assign pad_l = cfg.pad_offsets[2:0];
  assign ph    = (cfg.plane_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : cfg.plane_height;
  assign pw    = (cfg.plane_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : cfg.plane_width;

  // window bounds, signed 12 bits cover pos*stride - pad + k
  logic signed [11:0] rs, re, cs, ce;
  logic [6:0] r0_r, r1_r, c0_r, c1_r, r_r, c_r;
  logic [5:0] row_r, col_r;

  assign rs = $signed({1'b0, 10'(row_r) * 10'(cfg.stride_height)}) - 12'(pad_t);
  assign re = rs + 12'(kh);
  assign cs = $signed({1'b0, 10'(col_r) * 10'(cfg.stride_width)}) - 12'(pad_l);
  assign ce = cs + 12'(kw);

  logic             ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [15:0]      ram_rdata;
  logic             rd_v_r;

  wpe_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(in_sample), .rdata(ram_rdata)
  );

  logic accept;
  assign accept   = start && !busy;
  assign ram_we   = accept && !in_kind;
  assign ram_addr = accept ? {in_row, in_col} : {r_r[5:0], c_r[5:0]};
  assign busy     = (state_r != S_IDLE);

  logic signed [SUM_W-1:0] sum_r;
  logic signed [15:0]      mx_r;
  logic                    first_r;
  logic [6:0]              cells_r;
  logic                    neg;
  logic [SUM_W-1:0]        mag;
  logic [DIV_W-1:0]        dsel;
  logic                    div_start, div_done;
  logic [MAG_W-1:0]        quo;

  assign neg  = sum_r[SUM_W-1];
  assign mag  = neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign dsel = (cfg.pool_mode == MODE_CLIP) ? cells_r : DIV_W'(kh) * DIV_W'(kw);

  wpe_divider u_div (
    .clk, .rst_n, .start(div_start),
    .dividend({mag, 1'b0} + MAG_W'(dsel)),
    .divisor({dsel, 1'b0}),
    .done(div_done), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      rd_v_r    <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      div_start <= 1'b0;
      rd_v_r    <= 1'b0;
      if (rd_v_r) begin
        sum_r   <= sum_r + SUM_W'($signed(ram_rdata));
        if (first_r || $signed(ram_rdata) > mx_r) mx_r <= ram_rdata;
        first_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (accept && in_kind) begin
          row_r   <= in_row;
          col_r   <= in_col;
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          r0_r    <= (rs < 0) ? 7'd0 : rs[6:0];
          r1_r    <= (re > $signed({5'd0, ph})) ? ph : re[6:0];
          c0_r    <= (cs < 0) ? 7'd0 : cs[6:0];
          c1_r    <= (ce > $signed({5'd0, pw})) ? pw : ce[6:0];
          r_r     <= (rs < 0) ? 7'd0 : rs[6:0];
          c_r     <= (cs < 0) ? 7'd0 : cs[6:0];
          sum_r   <= '0;
          first_r <= 1'b1;
          if (pad_t >= 3'(kh) && kh < 4'd8 || pad_l >= 3'(kw) && kw < 4'd8
              || kh == 4'd0 || kw == 4'd0 || cfg.pool_mode == MODE_BAD) begin
            out_valid <= 1'b1; out_status <= ST_UNSUP;
            out_pooled_value <= '0; out_cells_used <= '0;
            state_r <= S_IDLE;
          end else if (re <= rs || re <= 0 || rs >= $signed({5'd0, ph})
                       || ce <= 0 || cs >= $signed({5'd0, pw})
                       || ph == 7'd0 || pw == 7'd0) begin
            out_valid <= 1'b1; out_status <= ST_EMPTY;
            out_pooled_value <= '0; out_cells_used <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_v_r <= 1'b1;
          if (c_r + 7'd1 >= c1_r) begin
            c_r <= c0_r;
            r_r <= r_r + 7'd1;
            if (r_r + 7'd1 >= r1_r) state_r <= S_LAST;
          end else begin
            c_r <= c_r + 7'd1;
          end
        end
        S_LAST: begin
          if (!rd_v_r) begin
            cells_r <= 7'((r1_r - r0_r) * (c1_r - c0_r));
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (cfg.pool_mode == MODE_MAX) begin
            out_valid <= 1'b1; out_status <= ST_OK;
            out_pooled_value <= mx_r; out_cells_used <= cells_r;
            state_r <= S_IDLE;
          end else begin
            div_start <= 1'b1;
            state_r   <= S_WAIT;
          end
        end
        S_WAIT: if (div_done) begin
          out_valid <= 1'b1; out_status <= ST_OK;
          out_pooled_value <= neg ? -16'(quo) : 16'(quo);
          out_cells_used <= cells_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/wpe_ram.sv -----
// ----------------------------------------------------------------------------
// wpe_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/wpe_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// wpe_cfg_regs
// Configuration register file.
// ----------------------------------------------------------------------------
module wpe_cfg_regs
  import wpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pool_mode: 2'd0, kernel_height: 4'd2, kernel_width: 4'd2,
                 stride_height: 4'd2, stride_width: 4'd2, pad_offsets: 6'd0,
                 plane_height: 7'd64, plane_width: 7'd64};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: cfg_r.pool_mode     <= cfg_data[1:0];
        REG_KH:   cfg_r.kernel_height <= cfg_data[3:0];
        REG_KW:   cfg_r.kernel_width  <= cfg_data[3:0];
        REG_SH:   cfg_r.stride_height <= cfg_data[3:0];
        REG_SW:   cfg_r.stride_width  <= cfg_data[3:0];
        REG_PAD:  cfg_r.pad_offsets   <= cfg_data[5:0];
        REG_PH:   cfg_r.plane_height  <= cfg_data[6:0];
        REG_PW:   cfg_r.plane_width   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/wpe_divider.sv -----
// ----------------------------------------------------------------------------
// wpe_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpe_divider
  import wpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [DIV_W:0]   divisor,    // 2*d
  output logic             done,
  output logic [MAG_W-1:0] quotient
);

  logic [MAG_W-1:0] q_r;
  logic [DIV_W+1:0] rem_r;
  logic [4:0]       cnt_r;
  logic             run_r;
  logic [DIV_W:0]   dv_r;
  logic [DIV_W+1:0] trial;

  assign trial    = {rem_r[DIV_W:0], q_r[MAG_W-1]};
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'(MAG_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, dv_r}) begin
        rem_r <= trial - {1'b0, dv_r};
        q_r   <= {q_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[MAG_W-2:0], 1'b0};
      end
    end
  end

endmodule
